### rtl/gf2pa_pkg.sv
// ----------------------------------------------------------------------------
// gf2pa_pkg
// Shared widths, mode codes and helpers for the GF(2) polynomial ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2pa_pkg;

   localparam int DEF_WIDTH   = 32;
   localparam int OPND_W      = 32;
   localparam int MAIN_W      = 63;
   localparam int REM_W       = 31;
   localparam int DEG_W       = 7;
   localparam int MODE_W      = 2;
   localparam int STAGE_STEPS = 4;   // bit steps per pipeline stage

   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIV = 2'd2;

   localparam logic [DEG_W-1:0] DEG_NONE = 7'h7F;   // -1, zero polynomial

   // index of the highest set bit, DEG_NONE for zero
   function automatic logic [DEG_W-1:0] poly_degree(input logic [MAIN_W-1:0] p);
      logic [DEG_W-1:0] d;
      d = DEG_NONE;
      for (int i = 0; i < MAIN_W; i++) begin
         if (p[i]) begin
            d = DEG_W'(i);
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/gf2_polynomial_alu.sv
// ----------------------------------------------------------------------------
// gf2_polynomial_alu
// Pipelined add / carry-less multiply / divide-with-remainder over GF(2).
// ----------------------------------------------------------------------------
// One word is accepted per clock while req_ready is high, and results
// leave in order. The pipeline is an input register that also finds the
// divisor's leading term, then ceil(WIDTH/4) stages that each retire four
// dividend bits (four shift-and-xor steps of the long division, or of the
// Horner-form product), then an output register that selects the result
// and encodes its degree. Every stage holds its word while the next one
// is full and stalled, so empty stages still fill behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_polynomial_alu #(
   parameter int WIDTH = gf2pa_pkg::DEF_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gf2pa_pkg::MODE_W-1:0]       req_mode,
   input  logic [gf2pa_pkg::OPND_W-1:0]       req_operand_a,
   input  logic [gf2pa_pkg::OPND_W-1:0]       req_operand_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gf2pa_pkg::MAIN_W-1:0]       rsp_main_result,
   output logic [gf2pa_pkg::REM_W-1:0]        rsp_remainder_out,
   output logic signed [gf2pa_pkg::DEG_W-1:0] rsp_result_degree,
   output logic                               rsp_divide_by_zero
);

   localparam int STEPS = gf2pa_pkg::STAGE_STEPS;
   localparam int NSTG  = (WIDTH + STEPS - 1) / STEPS;
   localparam int PADW  = NSTG * STEPS;
   localparam int PRODW = 2 * WIDTH - 1;

   // stage 0 is the input register, stages 1..NSTG the bit-step stages
   logic [NSTG:0]                   v_ff;
   logic [NSTG:0]                   v_in;
   logic [NSTG+1:0]                 rdy;

   logic [gf2pa_pkg::MODE_W-1:0]    mode_ff [0:NSTG];
   logic [PADW-1:0]                 a_ff    [0:NSTG];
   logic [WIDTH-1:0]                b_ff    [0:NSTG];
   logic [WIDTH-1:0]                top_ff  [0:NSTG];
   logic [PRODW-1:0]                acc_ff  [0:NSTG];
   logic [WIDTH-1:0]                r_ff    [0:NSTG];
   logic [WIDTH-1:0]                q_ff    [0:NSTG];

   logic [gf2pa_pkg::MODE_W-1:0]    mode_in [0:NSTG];
   logic [PADW-1:0]                 a_in    [0:NSTG];
   logic [WIDTH-1:0]                b_in    [0:NSTG];
   logic [WIDTH-1:0]                top_in  [0:NSTG];
   logic [PRODW-1:0]                acc_in  [0:NSTG];
   logic [WIDTH-1:0]                r_in    [0:NSTG];
   logic [WIDTH-1:0]                q_in    [0:NSTG];

   logic                            out_v_ff;
   logic [gf2pa_pkg::MAIN_W-1:0]    main_ff,  main_in;
   logic [gf2pa_pkg::REM_W-1:0]     rem_ff,   rem_in;
   logic [gf2pa_pkg::DEG_W-1:0]     deg_ff,   deg_in;
   logic                            dz_ff,    dz_in;

   // ---- flow control ----
   always_comb begin
      rdy[NSTG+1] = !out_v_ff || rsp_ready;
      for (int s = NSTG; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign v_in      = {v_ff[NSTG-1:0], req_valid};
   assign req_ready = rdy[0];

   // ---- datapath next values ----
   always_comb begin
      logic [WIDTH-1:0] opa;
      logic [WIDTH-1:0] smear;
      logic [PADW-1:0]  a_t;
      logic [PRODW-1:0] acc_t;
      logic [WIDTH-1:0] r_t;
      logic [WIDTH-1:0] q_t;
      logic             bit_t;
      logic             hit_t;

      // input stage: mask operands, find divisor leading term
      opa   = req_operand_a[WIDTH-1:0];
      b_in[0] = req_operand_b[WIDTH-1:0];
      smear = b_in[0];
      for (int k = 1; k < WIDTH; k = k * 2) begin
         smear = smear | (smear >> k);
      end
      top_in[0]  = smear & ~(smear >> 1);
      mode_in[0] = req_mode;
      a_in[0]    = PADW'(opa);
      acc_in[0]  = (req_mode == gf2pa_pkg::MODE_ADD) ? PRODW'(opa ^ b_in[0]) : '0;
      r_in[0]    = '0;
      q_in[0]    = '0;

      // bit-step stages, dividend / multiplier bits MSB first
      for (int s = 1; s <= NSTG; s++) begin
         a_t   = a_ff[s-1];
         acc_t = acc_ff[s-1];
         r_t   = r_ff[s-1];
         q_t   = q_ff[s-1];
         for (int k = 0; k < STEPS; k++) begin
            bit_t = a_t[PADW-1];
            a_t   = a_t << 1;
            if (mode_ff[s-1] == gf2pa_pkg::MODE_MUL) begin
               acc_t = (acc_t << 1) ^ (bit_t ? PRODW'(b_ff[s-1]) : '0);
            end
            r_t   = {r_t[WIDTH-2:0], bit_t};
            hit_t = |(r_t & top_ff[s-1]);
            if (hit_t) begin
               r_t = r_t ^ b_ff[s-1];
            end
            q_t = {q_t[WIDTH-2:0], hit_t};
         end
         mode_in[s] = mode_ff[s-1];
         a_in[s]    = a_t;
         b_in[s]    = b_ff[s-1];
         top_in[s]  = top_ff[s-1];
         acc_in[s]  = acc_t;
         r_in[s]    = r_t;
         q_in[s]    = q_t;
      end
   end

   // ---- output select ----
   always_comb begin
      main_in = '0;
      rem_in  = '0;
      dz_in   = 1'b0;
      unique case (mode_ff[NSTG])
         gf2pa_pkg::MODE_ADD,
         gf2pa_pkg::MODE_MUL: begin
            main_in = gf2pa_pkg::MAIN_W'(acc_ff[NSTG]);
         end
         gf2pa_pkg::MODE_DIV: begin
            if (top_ff[NSTG] == '0) begin
               dz_in = 1'b1;
            end else begin
               main_in = gf2pa_pkg::MAIN_W'(q_ff[NSTG]);
               rem_in  = gf2pa_pkg::REM_W'(r_ff[NSTG]);
            end
         end
         default: begin
            main_in = '0;
         end
      endcase
      deg_in = gf2pa_pkg::poly_degree(main_in);
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         for (int s = 0; s <= NSTG; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= v_in[s];
            end
         end
         if (rdy[NSTG+1]) begin
            out_v_ff <= v_ff[NSTG];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NSTG; s++) begin
         if (rdy[s]) begin
            mode_ff[s] <= mode_in[s];
            a_ff[s]    <= a_in[s];
            b_ff[s]    <= b_in[s];
            top_ff[s]  <= top_in[s];
            acc_ff[s]  <= acc_in[s];
            r_ff[s]    <= r_in[s];
            q_ff[s]    <= q_in[s];
         end
      end
      if (rdy[NSTG+1]) begin
         main_ff <= main_in;
         rem_ff  <= rem_in;
         deg_ff  <= deg_in;
         dz_ff   <= dz_in;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_main_result    = main_ff;
   assign rsp_remainder_out  = rem_ff;
   assign rsp_result_degree  = deg_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

`default_nettype wire

### rtl/gf2pa_checker.sv
// ----------------------------------------------------------------------------
// gf2pa_checker
// Port-level checks on the result channel of the GF(2) polynomial ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2pa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [gf2pa_pkg::MAIN_W-1:0]       rsp_main_result,
   input logic [gf2pa_pkg::REM_W-1:0]        rsp_remainder_out,
   input logic signed [gf2pa_pkg::DEG_W-1:0] rsp_result_degree,
   input logic                               rsp_divide_by_zero
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_main_result)
         && $stable(rsp_remainder_out) && $stable(rsp_result_degree)
         && $stable(rsp_divide_by_zero))
      else $error("result word changed while stalled");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_main_result == '0
         && rsp_remainder_out == '0 && rsp_result_degree == gf2pa_pkg::DEG_NONE)
      else $error("divide by zero with nonzero results");

   a_deg_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_main_result == '0 |->
         rsp_result_degree == gf2pa_pkg::DEG_NONE)
      else $error("zero result with a degree");

   a_deg_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_main_result != '0 |-> !rsp_result_degree[6]
         && ((rsp_main_result >> rsp_result_degree[5:0]) == 63'd1))
      else $error("degree does not match leading term");

endmodule

bind gf2_polynomial_alu gf2pa_checker u_gf2pa_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_main_result    (rsp_main_result),
   .rsp_remainder_out  (rsp_remainder_out),
   .rsp_result_degree  (rsp_result_degree),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

`default_nettype wire
